// ===== sv/tfs_pkg.sv =====
// Package for the tridiagonal forward sweep: fixed-point widths and item structs.
// Used by tridiagonal_forward_sweep; depends on nothing else.
package tfs_pkg;

  // Signed fixed point Q16.16.
  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;

  // Product of two words, pivot and numerator after the product shift,
  // numerator after the pre-divide shift.
  localparam int unsigned ProdW = 2 * WordBits;
  localparam int unsigned PivW  = 2 * WordBits - FracBits + 1;
  localparam int unsigned NumW  = PivW + FracBits;

  // Quotient bits resolved by the divider (two bits per cycle) and its step count.
  localparam int unsigned QuoW     = WordBits + 2;
  localparam int unsigned DivIters = QuoW / 2;
  localparam int unsigned CntW     = $clog2(DivIters);

  typedef struct packed {
    logic signed [WordBits-1:0] sub_diag;
    logic signed [WordBits-1:0] main_diag;
    logic signed [WordBits-1:0] super_diag;
    logic signed [WordBits-1:0] rhs_value;
    logic                       first_row;
  } tfs_in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] mod_super;
    logic signed [WordBits-1:0] mod_rhs;
    logic                       pivot_zero;
    logic                       overflowed;
  } tfs_out_t;

endpackage

// ===== sv/tridiagonal_forward_sweep.sv =====
// Forward sweep of the Thomas algorithm, one tridiagonal row per item.
// Depends on tfs_pkg for widths and the item structs.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------
//   in      | input     | in_valid_i/in_stall_o   | tfs_pkg::tfs_in_t
//   out     | output    | out_valid_o/out_stall_i | tfs_pkg::tfs_out_t
//
// From acceptance to its result in the output register, an item passes through the two products,
// the two divisions of the shared radix-4 restoring divider, and the sequencing states.
// A zero pivot skips both divisions, and a division out of range from its start skips its remaining run steps.
// The next item is accepted the cycle after the result is loaded, even if that result is still
// stalled; a stalled result holds the sequencer in its last state.
// Reset returns the sequencer to idle and clears the output valid and the stored previous row to zero.
module tridiagonal_forward_sweep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfs_pkg::tfs_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfs_pkg::tfs_out_t out_item_o
);

  localparam int unsigned W  = tfs_pkg::WordBits;
  localparam int unsigned F  = tfs_pkg::FracBits;
  localparam int unsigned PW = tfs_pkg::PivW;
  localparam int unsigned NW = tfs_pkg::NumW;
  localparam int unsigned QW = tfs_pkg::QuoW;
  localparam int unsigned CW = tfs_pkg::CntW;

  localparam logic [QW-1:0] MaxPosQ = QW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [QW-1:0] MaxNegQ = QW'(64'd1 << (W - 1));
  localparam logic [W-1:0]  SatPos  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  SatNeg  = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [8:0] {
    StIdle    = 9'b000000001,
    StMulG    = 9'b000000010,
    StMulD    = 9'b000000100,
    StRnum    = 9'b000001000,
    StDivInit = 9'b000010000,
    StDivChk  = 9'b000100000,
    StDivRun  = 9'b001000000,
    StDivEnd  = 9'b010000000,
    StDone    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Captured row and previous-row state.
  logic signed [W-1:0]  a_q, b_q, c_q, d_q;
  logic                 first_q;
  logic signed [W-1:0]  prev_g_q, prev_r_q;

  // Shared multiplier and the values formed from its products.
  logic signed [W-1:0]  mul_op;
  logic signed [tfs_pkg::ProdW-1:0] prod_q;
  logic signed [PW-1:0] prod_sh;
  logic signed [PW-1:0] piv_q, rnum_q;

  // Divider.
  logic                 sel_q;
  logic signed [PW-1:0] num_sel;
  logic signed [NW-1:0] num_sh;
  logic [NW-1:0]        un_q;
  logic [PW-1:0]        ud_q;
  logic                 neg_q;
  logic [PW-1:0]        rem_q;
  logic [QW-1:0]        low_q, quo_q;
  logic [CW-1:0]        cnt_q;
  logic                 big_q;
  logic [PW-1:0]        rem_t;
  logic [QW-1:0]        low_t, quo_t;
  logic [PW:0]          trial;
  logic                 q_sat;
  logic [QW-1:0]        q_neg;
  logic [W-1:0]         q_val;

  // Per-row results.
  logic signed [W-1:0]  g_res_q, r_res_q;
  logic                 sat_q, zero_q;

  logic                 out_valid_q;
  tfs_pkg::tfs_out_t    out_q;
  logic                 out_load;
  logic                 in_fire;

  assign in_stall_o  = (state_q != StIdle);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // A first row uses zero for the previous modified values.
  assign mul_op  = first_q ? '0 : ((state_q == StMulG) ? prev_g_q : prev_r_q);
  assign prod_sh = PW'(prod_q >>> F);

  assign num_sel = sel_q ? rnum_q : PW'(c_q);
  assign num_sh  = {num_sel, {F{1'b0}}};

  // Two restoring steps per cycle; the remainder stays below the divisor unless the quotient overflows.
  always_comb begin
    rem_t = rem_q;
    low_t = low_q;
    quo_t = quo_q;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_t, low_t[QW-1]};
      low_t = {low_t[QW-2:0], 1'b0};
      if (trial >= {1'b0, ud_q}) begin
        rem_t = PW'(trial - {1'b0, ud_q});
        quo_t = {quo_t[QW-2:0], 1'b1};
      end else begin
        rem_t = PW'(trial);
        quo_t = {quo_t[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    q_neg = QW'(-quo_q);
    q_sat = big_q || (neg_q ? (quo_q > MaxNegQ) : (quo_q > MaxPosQ));
    if (q_sat) begin
      q_val = neg_q ? SatNeg : SatPos;
    end else begin
      q_val = neg_q ? q_neg[W-1:0] : quo_q[W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_fire) state_d = StMulG;
      StMulG:    state_d = StMulD;
      StMulD:    state_d = StRnum;
      StRnum:    state_d = (piv_q == '0) ? StDone : StDivInit;
      StDivInit: state_d = StDivChk;
      StDivChk:  state_d = StDivRun;
      StDivRun:  if (big_q || cnt_q == '0) state_d = StDivEnd;
      StDivEnd:  state_d = sel_q ? StDone : StDivInit;
      StDone:    if (out_load) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      prev_g_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        prev_g_q    <= g_res_q;
        prev_r_q    <= r_res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q     <= in_item_i.sub_diag;
      b_q     <= in_item_i.main_diag;
      c_q     <= in_item_i.super_diag;
      d_q     <= in_item_i.rhs_value;
      first_q <= in_item_i.first_row;
    end
    if (state_q == StMulG || state_q == StMulD) begin
      prod_q <= mul_op * a_q;
    end
    if (state_q == StMulD) begin
      piv_q <= PW'(b_q) - prod_sh;
    end
    if (state_q == StRnum) begin
      rnum_q  <= PW'(d_q) - prod_sh;
      sel_q   <= 1'b0;
      sat_q   <= 1'b0;
      zero_q  <= (piv_q == '0);
      g_res_q <= '0;
      r_res_q <= '0;
    end
    if (state_q == StDivInit) begin
      un_q  <= num_sh[NW-1] ? NW'(-num_sh) : num_sh;
      ud_q  <= piv_q[PW-1] ? PW'(-piv_q) : piv_q;
      neg_q <= num_sh[NW-1] ^ piv_q[PW-1];
    end
    if (state_q == StDivChk) begin
      // The quotient reaches 2**QW exactly when the bits above QW reach the divisor.
      big_q <= (PW'(un_q[NW-1:QW]) >= ud_q);
      rem_q <= PW'(un_q[NW-1:QW]);
      low_q <= un_q[QW-1:0];
      quo_q <= '0;
      cnt_q <= CW'(tfs_pkg::DivIters - 1);
    end
    if (state_q == StDivRun) begin
      rem_q <= rem_t;
      low_q <= low_t;
      quo_q <= quo_t;
      cnt_q <= cnt_q - 1'b1;
    end
    if (state_q == StDivEnd) begin
      sat_q <= sat_q | q_sat;
      sel_q <= 1'b1;
      if (sel_q) begin
        r_res_q <= q_val;
      end else begin
        g_res_q <= q_val;
      end
    end
    if (out_load) begin
      out_q.mod_super  <= g_res_q;
      out_q.mod_rhs    <= r_res_q;
      out_q.pivot_zero <= zero_q;
      out_q.overflowed <= sat_q;
    end
  end

  a_rise_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StDone))
    else $error("result appeared without a finished row");

  a_zero_pivot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pivot_zero |->
      out_item_o.mod_super == '0 && out_item_o.mod_rhs == '0 && !out_item_o.overflowed)
    else $error("zero pivot gave a nonzero result");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDivRun && !big_q |-> rem_q < ud_q)
    else $error("divider remainder not below divisor");

  a_accept_starts_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == StMulG)
    else $error("accepted item did not start the sequencer");

endmodule

// ===== tb/sv/tridiagonal_forward_sweep_tb.sv =====
// Testbench for tridiagonal_forward_sweep: drives tridiagonal rows, predicts each
// modified super-diagonal and right-hand side in wide signed arithmetic and checks
// every result item in order. Depends on tfs_pkg and the block itself.
module tridiagonal_forward_sweep_tb;

  localparam int unsigned WordBits = tfs_pkg::WordBits;
  localparam int unsigned FracBits = tfs_pkg::FracBits;

  localparam logic signed [WordBits-1:0] MaxWord = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] MinWord = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic signed [WordBits-1:0] FixOne  = 1 <<< FracBits;
  localparam logic signed [WordBits-1:0] FixTiny = 1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              out_stall_i = 1'b0;
  tfs_pkg::tfs_in_t  in_item_i   = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  tfs_pkg::tfs_out_t out_item_o;

  // Previous row as the block should hold it, and results still to come.
  logic signed [WordBits-1:0] last_mod_super = '0;
  logic signed [WordBits-1:0] last_mod_rhs   = '0;
  tfs_pkg::tfs_out_t          expected_sweeps[$];
  int                         mismatch_count = 0;
  logic                       calm = 1'b0;

  tridiagonal_forward_sweep dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tridiagonal_forward_sweep_tb: errors");
    $finish;
  end

  // (num << FracBits) / den truncated toward zero, then saturated to one word.
  function automatic logic signed [WordBits-1:0] fixed_quotient(
    input logic signed [127:0] num,
    input logic signed [127:0] den,
    inout logic                sat
  );
    logic signed [127:0] q;
    q = (num <<< FracBits) / den;
    if (q > MaxWord) begin
      sat = 1'b1;
      return MaxWord;
    end
    if (q < MinWord) begin
      sat = 1'b1;
      return MinWord;
    end
    return q[WordBits-1:0];
  endfunction

  // One step of the forward sweep; updates the stored previous row.
  function automatic tfs_pkg::tfs_out_t sweep_row(input tfs_pkg::tfs_in_t row);
    logic signed [127:0] wa, wb, wc, wd, wgp, wdp, piv, num_rhs;
    logic                sat;
    tfs_pkg::tfs_out_t   res;
    wa = $signed(row.sub_diag);
    wb = $signed(row.main_diag);
    wc = $signed(row.super_diag);
    wd = $signed(row.rhs_value);
    wgp = row.first_row ? 128'sd0 : 128'($signed(last_mod_super));
    wdp = row.first_row ? 128'sd0 : 128'($signed(last_mod_rhs));
    piv = wb - ((wgp * wa) >>> FracBits);
    num_rhs = wd - ((wdp * wa) >>> FracBits);
    sat = 1'b0;
    res = '0;
    if (piv == 0) begin
      res.pivot_zero = 1'b1;
    end else begin
      res.mod_super = fixed_quotient(wc, piv, sat);
      res.mod_rhs   = fixed_quotient(num_rhs, piv, sat);
    end
    res.overflowed = sat;
    last_mod_super = res.mod_super;
    last_mod_rhs   = res.mod_rhs;
    return res;
  endfunction

  task automatic send_row(
    input logic signed [WordBits-1:0] a,
    input logic signed [WordBits-1:0] b,
    input logic signed [WordBits-1:0] c,
    input logic signed [WordBits-1:0] d,
    input logic                       first
  );
    tfs_pkg::tfs_in_t row;
    row.sub_diag   = a;
    row.main_diag  = b;
    row.super_diag = c;
    row.rhs_value  = d;
    row.first_row  = first;
    // Gaps up to about one item time land on every phase of the sequencer.
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_sweeps.insert(expected_sweeps.size(), sweep_row(row));
  endtask

  task automatic compare_field(input string name, input logic [WordBits-1:0] want,
                               input logic [WordBits-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  // Output side: check each accepted result item, then pick the next stall.
  always @(posedge clk_i) begin
    tfs_pkg::tfs_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sweeps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item %h", out_item_o);
      end else begin
        want = expected_sweeps.pop_front();
        compare_field("mod_super", want.mod_super, out_item_o.mod_super);
        compare_field("mod_rhs", want.mod_rhs, out_item_o.mod_rhs);
        compare_field("pivot_zero", want.pivot_zero, out_item_o.pivot_zero);
        compare_field("overflowed", want.overflowed, out_item_o.overflowed);
      end
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 12);
  end

  function automatic logic signed [WordBits-1:0] pick_coeff(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 32'h3_FFFF))) - 32'sh2_0000;
      default: begin
        case ($urandom_range(0, 6))
          0: return MaxWord;
          1: return MinWord;
          2: return '0;
          3: return FixOne;
          4: return -FixOne;
          5: return FixTiny;
          default: return -FixTiny;
        endcase
      end
    endcase
  endfunction

  // Before any first row the reset state serves as the previous row.
  task automatic test_rows_before_first_row();
    send_row(MaxWord, 2 * FixOne, FixOne, -3 * FixOne, 1'b0);
    send_row(FixOne, 3 * FixOne, -FixOne, FixOne, 1'b0);
  endtask

  task automatic test_recurrence();
    send_row('0, 4 * FixOne, FixOne, FixOne, 1'b1);
    send_row(FixOne, 4 * FixOne, FixOne, 2 * FixOne, 1'b0);
    send_row(-FixOne, 4 * FixOne, -FixOne, -3 * FixOne, 1'b0);
    send_row(FixOne, -5 * FixOne, '0, 7 * FixOne, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_row(MinWord, MinWord, MinWord, MinWord, 1'b1);
    send_row(MaxWord, MaxWord, MaxWord, MaxWord, 1'b0);
    send_row(MaxWord, MaxWord, MaxWord, MaxWord, 1'b1);
    send_row(MinWord, MaxWord, MinWord, MaxWord, 1'b0);
    send_row(-FixTiny, -FixTiny, -FixTiny, -FixTiny, 1'b1);
  endtask

  task automatic test_zero_pivot();
    send_row(FixOne, '0, FixOne, FixOne, 1'b1);
    send_row('0, FixOne, FixOne, 2 * FixOne, 1'b1);
    // The stored super-diagonal of one cancels the diagonal exactly here.
    send_row(FixOne, FixOne, 5 * FixOne, 5 * FixOne, 1'b0);
    send_row(FixOne, 2 * FixOne, FixOne, FixOne, 1'b0);
  endtask

  task automatic test_saturation();
    send_row('0, FixTiny, MaxWord, FixOne, 1'b1);
    send_row('0, FixTiny, MinWord, -FixOne, 1'b1);
    send_row('0, FixOne, FixOne, MaxWord, 1'b1);
    send_row('0, -FixOne, MinWord, '0, 1'b1);
    send_row('0, FixOne, MinWord, MinWord, 1'b1);
    send_row(MaxWord, FixTiny, FixOne, FixOne, 1'b0);
  endtask

  // Mostly well-formed systems with a flagged first row; some carry stray flags
  // or raw bit patterns so that every bit and the saturation paths are reached.
  task automatic test_random_systems(input int rows);
    int sent, len, kind;
    logic signed [WordBits-1:0] a, b, c, d;
    logic first;
    sent = 0;
    while (sent < rows) begin
      len  = $urandom_range(1, 12);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < len && sent < rows; i++) begin
        calm = (sent >= 300 && sent < 450);
        if (kind < 7) begin
          a = pick_coeff(1);
          c = pick_coeff(1);
          d = pick_coeff(1);
          b = (a < 0 ? -a : a) + (c < 0 ? -c : c) + $urandom_range(1, 32'h4_0000);
          if ($urandom_range(0, 1)) b = -b;
        end else begin
          a = pick_coeff(kind == 9 ? 2 : 0);
          b = pick_coeff(kind == 9 ? 2 : 0);
          c = pick_coeff(kind == 9 ? 2 : 0);
          d = pick_coeff(kind == 9 ? 2 : 0);
        end
        first = (i == 0);
        if ($urandom_range(0, 99) < 8) first = !first;
        send_row(a, b, c, d, first);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rows_before_first_row();
    test_recurrence();
    test_field_extremes();
    test_zero_pivot();
    test_saturation();
    test_random_systems(850);
    in_valid_i <= 1'b0;
    while (expected_sweeps.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tridiagonal_forward_sweep_tb: clean");
    else
      $display("tridiagonal_forward_sweep_tb: errors");
    $finish;
  end

endmodule
